// ===== sv/ivds_pkg.sv =====
// Shared constants, widths and bundle types for the int8 vector distance sums block.
`timescale 1ns / 1ps

package ivds_pkg;

  // Lane count and longest vector that the sums are bounded for
  localparam int LANES   = 4;
  localparam int MAX_DIM = 4096;

  localparam int ELEM_W = 8;

  // Per-lane term widths: (a-b)^2 <= 65025, a*b in [-16256, 16384], a*a <= 16384
  localparam int LANE_SQ_W  = 16;
  localparam int LANE_DOT_W = 16;
  localparam int LANE_NRM_W = 15;

  // Growth of a sum over all lanes
  localparam int LANE_GROW = $clog2(LANES);
  localparam int SUM_SQ_W  = LANE_SQ_W + LANE_GROW;
  localparam int SUM_DOT_W = LANE_DOT_W + LANE_GROW;
  localparam int SUM_NRM_W = LANE_NRM_W + LANE_GROW;

  // Lane count per item and running element count
  localparam int CNT_IN_W = $clog2(LANES + 1);
  localparam int CNT_W    = $clog2(MAX_DIM + 1);

  // Result widths
  localparam int SQ_W  = 28;
  localparam int DOT_W = 28;
  localparam int NRM_W = 27;

  // Saturation bounds of the running sums
  localparam logic [SQ_W-1:0] SQD_MAX = SQ_W'(longint'(MAX_DIM) * 65025);
  localparam logic signed [DOT_W:0] DOT_HI = (DOT_W+1)'(longint'(MAX_DIM) * 16384);
  localparam logic signed [DOT_W:0] DOT_LO = (DOT_W+1)'(-(longint'(MAX_DIM) * 16256));
  localparam logic [NRM_W-1:0] NRM_MAX = NRM_W'(longint'(MAX_DIM) * 16384);

  // Terms found by one lane
  typedef struct packed {
    logic [LANE_SQ_W-1:0]         sq;
    logic signed [LANE_DOT_W-1:0] dot;
    logic [LANE_NRM_W-1:0]        na;
    logic [LANE_NRM_W-1:0]        nb;
  } ivds_lane_t;

  // Control that travels beside the lane terms
  typedef struct packed {
    logic [CNT_IN_W-1:0] cnt;
    logic                last;
  } ivds_ctl_t;

  // Per-request sums over all lanes
  typedef struct packed {
    logic [SUM_SQ_W-1:0]         sq;
    logic signed [SUM_DOT_W-1:0] dot;
    logic [SUM_NRM_W-1:0]        na;
    logic [SUM_NRM_W-1:0]        nb;
    logic [CNT_IN_W-1:0]         cnt;
    logic                        last;
  } ivds_sums_t;

endpackage

// ===== sv/ivds_lane.sv =====
// One lane: squared difference, product and both squares of an element pair.
`timescale 1ns / 1ps

module ivds_lane import ivds_pkg::*; (
  input  logic                     clk_i,
  input  logic                     load_i,
  input  logic                     lane_on_i,
  input  logic signed [ELEM_W-1:0] a_i,
  input  logic signed [ELEM_W-1:0] b_i,
  output ivds_lane_t               res_o
);

  logic signed [ELEM_W:0]       diff;
  logic signed [2*ELEM_W+1:0]   diff_sq;
  logic signed [2*ELEM_W-1:0]   prod_ab;
  logic signed [2*ELEM_W-1:0]   prod_aa;
  logic signed [2*ELEM_W-1:0]   prod_bb;
  ivds_lane_t                   res_d;
  ivds_lane_t                   res_q;

  always_comb begin
    diff    = (ELEM_W+1)'(a_i) - (ELEM_W+1)'(b_i);
    diff_sq = diff * diff;
    prod_ab = a_i * b_i;
    prod_aa = a_i * a_i;
    prod_bb = b_i * b_i;
    res_d   = '0;
    // drop the lane's terms when it lies beyond the request's count
    if (lane_on_i) begin
      res_d.sq  = diff_sq[LANE_SQ_W-1:0];
      res_d.dot = prod_ab[LANE_DOT_W-1:0];
      res_d.na  = prod_aa[LANE_NRM_W-1:0];
      res_d.nb  = prod_bb[LANE_NRM_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== sv/ivds_merge.sv =====
// Merge stage: adds the terms of all lanes into per-request sums.
`timescale 1ns / 1ps

module ivds_merge import ivds_pkg::*; (
  input  logic       clk_i,
  input  logic       load_i,
  input  ivds_lane_t lanes_i [LANES],
  input  ivds_ctl_t  ctl_i,
  output ivds_sums_t sums_o
);

  ivds_sums_t sums_d;
  ivds_sums_t sums_q;

  always_comb begin
    sums_d      = '0;
    sums_d.cnt  = ctl_i.cnt;
    sums_d.last = ctl_i.last;
    for (int i = 0; i < LANES; i++) begin
      sums_d.sq  = sums_d.sq + SUM_SQ_W'(lanes_i[i].sq);
      sums_d.dot = sums_d.dot + SUM_DOT_W'(lanes_i[i].dot);
      sums_d.na  = sums_d.na + SUM_NRM_W'(lanes_i[i].na);
      sums_d.nb  = sums_d.nb + SUM_NRM_W'(lanes_i[i].nb);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sums_q <= sums_d;
    end
  end

  assign sums_o = sums_q;

endmodule

// ===== sv/ivds_accum.sv =====
// Accumulator: saturating running sums, element count and result register.
`timescale 1ns / 1ps

module ivds_accum import ivds_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    item_valid_i,
  input  ivds_sums_t              sums_i,
  output logic                    take_o,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic [SQ_W-1:0]         sum_sq_o,
  output logic signed [DOT_W-1:0] dot_o,
  output logic [NRM_W-1:0]        norm_a_o,
  output logic [NRM_W-1:0]        norm_b_o,
  output logic                    too_long_o
);

  logic [SQ_W-1:0]         acc_sq_q, acc_sq_d;
  logic signed [DOT_W-1:0] acc_dot_q, acc_dot_d;
  logic [NRM_W-1:0]        acc_na_q, acc_na_d;
  logic [NRM_W-1:0]        acc_nb_q, acc_nb_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    flag_q, flag_d;

  logic [SQ_W:0]           sq_sum;
  logic signed [DOT_W:0]   dot_sum;
  logic [NRM_W:0]          na_sum;
  logic [NRM_W:0]          nb_sum;
  logic [CNT_W:0]          cnt_sum;

  logic [SQ_W-1:0]         sq_sat;
  logic signed [DOT_W-1:0] dot_sat;
  logic [NRM_W-1:0]        na_sat;
  logic [NRM_W-1:0]        nb_sat;
  logic [CNT_W-1:0]        cnt_sat;
  logic                    over;

  logic                    out_valid_q;
  logic [SQ_W-1:0]         out_sq_q;
  logic signed [DOT_W-1:0] out_dot_q;
  logic [NRM_W-1:0]        out_na_q;
  logic [NRM_W-1:0]        out_nb_q;
  logic                    out_flag_q;

  logic                    emit;

  always_comb begin
    sq_sum  = {1'b0, acc_sq_q} + (SQ_W+1)'(sums_i.sq);
    dot_sum = (DOT_W+1)'(acc_dot_q) + (DOT_W+1)'(sums_i.dot);
    na_sum  = {1'b0, acc_na_q} + (NRM_W+1)'(sums_i.na);
    nb_sum  = {1'b0, acc_nb_q} + (NRM_W+1)'(sums_i.nb);
    cnt_sum = {1'b0, cnt_q} + (CNT_W+1)'(sums_i.cnt);

    sq_sat = (sq_sum > {1'b0, SQD_MAX}) ? SQD_MAX : sq_sum[SQ_W-1:0];
    if (dot_sum > DOT_HI) begin
      dot_sat = DOT_HI[DOT_W-1:0];
    end else if (dot_sum < DOT_LO) begin
      dot_sat = DOT_LO[DOT_W-1:0];
    end else begin
      dot_sat = dot_sum[DOT_W-1:0];
    end
    na_sat  = (na_sum > {1'b0, NRM_MAX}) ? NRM_MAX : na_sum[NRM_W-1:0];
    nb_sat  = (nb_sum > {1'b0, NRM_MAX}) ? NRM_MAX : nb_sum[NRM_W-1:0];
    over    = cnt_sum > (CNT_W+1)'(MAX_DIM);
    cnt_sat = over ? CNT_W'(MAX_DIM) : cnt_sum[CNT_W-1:0];
  end

  // a last request waits only while the result register is still full
  assign take_o = item_valid_i && (!sums_i.last || !out_valid_q || out_ready_i);
  assign emit   = take_o && sums_i.last;

  always_comb begin
    acc_sq_d  = acc_sq_q;
    acc_dot_d = acc_dot_q;
    acc_na_d  = acc_na_q;
    acc_nb_d  = acc_nb_q;
    cnt_d     = cnt_q;
    flag_d    = flag_q;
    if (take_o) begin
      if (sums_i.last) begin
        acc_sq_d  = '0;
        acc_dot_d = '0;
        acc_na_d  = '0;
        acc_nb_d  = '0;
        cnt_d     = '0;
        flag_d    = 1'b0;
      end else begin
        acc_sq_d  = sq_sat;
        acc_dot_d = dot_sat;
        acc_na_d  = na_sat;
        acc_nb_d  = nb_sat;
        cnt_d     = cnt_sat;
        flag_d    = flag_q | over;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_sq_q    <= '0;
      acc_dot_q   <= '0;
      acc_na_q    <= '0;
      acc_nb_q    <= '0;
      cnt_q       <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_sq_q  <= acc_sq_d;
      acc_dot_q <= acc_dot_d;
      acc_na_q  <= acc_na_d;
      acc_nb_q  <= acc_nb_d;
      cnt_q     <= cnt_d;
      flag_q    <= flag_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_sq_q   <= sq_sat;
      out_dot_q  <= dot_sat;
      out_na_q   <= na_sat;
      out_nb_q   <= nb_sat;
      out_flag_q <= flag_q | over;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sum_sq_o    = out_sq_q;
  assign dot_o       = out_dot_q;
  assign norm_a_o    = out_na_q;
  assign norm_b_o    = out_nb_q;
  assign too_long_o  = out_flag_q;

endmodule

// ===== sv/int8_vector_distance_sums.sv =====
// Top level of the int8 vector distance sums block: lanes, merge and accumulator.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid_i / in_ready_o): each request carries up to four
//   signed 8-bit element pairs, a count of valid lanes from lane 0 (counts
//   above four act as four) and a last_item marker. Lanes past the count are
//   ignored.
//   Output channel (out_valid_o / out_ready_i): one result per last request,
//   holding the saturated squared distance, dot product, both squared norms
//   and a flag set when the vector ran past MAX_DIM elements.
//   Path: a last request passes the lane product registers, the lane merge
//   register and the saturating accumulate into the result register.
//   Throughput: one request per cycle unless a last request is held back
//   as described under Stall; the saturating accumulate loop folds in each
//   taken request, and the four lanes each hold their own multipliers.
//   Stall: while a result waits for out_ready_i, requests that are not last
//   keep flowing into the sums; a last request holds in the merge stage
//   until the result register frees, and the stages behind it back up.
//   Reset: clears all sums, the element count, the overflow flag and every
//   valid bit; no result is pending afterwards.

module int8_vector_distance_sums import ivds_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,

  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [7:0]       a_lane0_i,
  input  logic signed [7:0]       a_lane1_i,
  input  logic signed [7:0]       a_lane2_i,
  input  logic signed [7:0]       a_lane3_i,
  input  logic signed [7:0]       b_lane0_i,
  input  logic signed [7:0]       b_lane1_i,
  input  logic signed [7:0]       b_lane2_i,
  input  logic signed [7:0]       b_lane3_i,
  input  logic [2:0]              valid_count_i,
  input  logic                    last_item_i,

  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [SQ_W-1:0]         sum_sq_diff_o,
  output logic signed [DOT_W-1:0] dot_sum_o,
  output logic [NRM_W-1:0]        norm_a_sq_o,
  output logic [NRM_W-1:0]        norm_b_sq_o,
  output logic                    too_long_o
);

  logic signed [ELEM_W-1:0] a_vec [LANES];
  logic signed [ELEM_W-1:0] b_vec [LANES];
  ivds_lane_t               lane_res [LANES];

  logic [CNT_IN_W-1:0] cnt_in;
  logic                in_acc;
  logic                lane_adv;
  logic                merge_ready;
  logic                take;

  // lane stage and merge stage valid bits
  logic      lane_vld_q, lane_vld_d;
  logic      merge_vld_q, merge_vld_d;
  ivds_ctl_t lane_ctl_q;
  ivds_sums_t sums;

  assign a_vec[0] = a_lane0_i;
  assign a_vec[1] = a_lane1_i;
  assign a_vec[2] = a_lane2_i;
  assign a_vec[3] = a_lane3_i;
  assign b_vec[0] = b_lane0_i;
  assign b_vec[1] = b_lane1_i;
  assign b_vec[2] = b_lane2_i;
  assign b_vec[3] = b_lane3_i;

  // clamp an oversized lane count to the lane total
  assign cnt_in = (valid_count_i > 3'(LANES)) ? CNT_IN_W'(LANES) : CNT_IN_W'(valid_count_i);

  // ready ripples back from the accumulator through both stages
  assign merge_ready = !merge_vld_q || take;
  assign lane_adv    = lane_vld_q && merge_ready;
  assign in_ready_o  = !lane_vld_q || merge_ready;
  assign in_acc      = in_valid_i && in_ready_o;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    ivds_lane u_lane (
      .clk_i     (clk_i),
      .load_i    (in_acc),
      .lane_on_i (CNT_IN_W'(g) < cnt_in),
      .a_i       (a_vec[g]),
      .b_i       (b_vec[g]),
      .res_o     (lane_res[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      lane_ctl_q.cnt  <= cnt_in;
      lane_ctl_q.last <= last_item_i;
    end
  end

  always_comb begin
    lane_vld_d = lane_vld_q;
    if (in_acc) begin
      lane_vld_d = 1'b1;
    end else if (lane_adv) begin
      lane_vld_d = 1'b0;
    end
    merge_vld_d = merge_vld_q;
    if (lane_adv) begin
      merge_vld_d = 1'b1;
    end else if (take) begin
      merge_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_vld_q  <= 1'b0;
      merge_vld_q <= 1'b0;
    end else begin
      lane_vld_q  <= lane_vld_d;
      merge_vld_q <= merge_vld_d;
    end
  end

  ivds_merge u_merge (
    .clk_i   (clk_i),
    .load_i  (lane_adv),
    .lanes_i (lane_res),
    .ctl_i   (lane_ctl_q),
    .sums_o  (sums)
  );

  ivds_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (merge_vld_q),
    .sums_i       (sums),
    .take_o       (take),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .sum_sq_o     (sum_sq_diff_o),
    .dot_o        (dot_sum_o),
    .norm_a_o     (norm_a_sq_o),
    .norm_b_o     (norm_b_sq_o),
    .too_long_o   (too_long_o)
  );

endmodule

// ===== test/ivds_distance_checker.sv =====
// Checker that predicts and compares the four distance sums of each vector pair.
`timescale 1ns / 1ps

module ivds_distance_checker import ivds_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic [LANES-1:0][7:0]   a_lanes_i,
  input  logic [LANES-1:0][7:0]   b_lanes_i,
  input  logic [2:0]              valid_count_i,
  input  logic                    last_item_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic [SQ_W-1:0]         sum_sq_diff_i,
  input  logic signed [DOT_W-1:0] dot_sum_i,
  input  logic [NRM_W-1:0]        norm_a_sq_i,
  input  logic [NRM_W-1:0]        norm_b_sq_i,
  input  logic                    too_long_i,
  output int                      fail_count_o,
  output int                      pending_o,
  output int                      results_o,
  output int                      overlong_o,
  output int                      bounded_o
);

  typedef logic [LANES-1:0][7:0] lane_vec_t;

  typedef struct packed {
    logic [SQ_W-1:0]         sq;
    logic signed [DOT_W-1:0] dot;
    logic [NRM_W-1:0]        na;
    logic [NRM_W-1:0]        nb;
    logic                    too_long;
  } pair_sums_t;

  localparam longint SQ_CEIL   = longint'(MAX_DIM) * 65025;
  localparam longint DOT_CEIL  = longint'(MAX_DIM) * 16384;
  localparam longint DOT_FLOOR = -(longint'(MAX_DIM) * 16256);
  localparam longint NRM_CEIL  = longint'(MAX_DIM) * 16384;

  // Running sums of the pair in flight
  longint     sq_run;
  longint     dot_run;
  longint     na_run;
  longint     nb_run;
  int         elem_run;
  logic       overlong_run;

  pair_sums_t expected_sums_q[$];
  pair_sums_t head;

  function automatic longint clamp_sum(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void clear_sums();
    sq_run       = 0;
    dot_run      = 0;
    na_run       = 0;
    nb_run       = 0;
    elem_run     = 0;
    overlong_run = 1'b0;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      fail_count_o++;
    end
  endfunction

  // Fold one request into the sums; on the last request queue the result and clear
  function automatic void accumulate_distance_sums(lane_vec_t a, lane_vec_t b,
                                                   logic [2:0] cnt, logic last);
    int         used;
    longint     ai;
    longint     bi;
    longint     sq;
    longint     dot;
    longint     na;
    longint     nb;
    pair_sums_t res;
    used = (int'(cnt) > LANES) ? LANES : int'(cnt);
    sq   = 0;
    dot  = 0;
    na   = 0;
    nb   = 0;
    for (int i = 0; i < used; i++) begin
      ai  = longint'($signed(a[i]));
      bi  = longint'($signed(b[i]));
      sq  += (ai - bi) * (ai - bi);
      dot += ai * bi;
      na  += ai * ai;
      nb  += bi * bi;
    end
    sq_run  = clamp_sum(sq_run + sq, 0, SQ_CEIL);
    dot_run = clamp_sum(dot_run + dot, DOT_FLOOR, DOT_CEIL);
    na_run  = clamp_sum(na_run + na, 0, NRM_CEIL);
    nb_run  = clamp_sum(nb_run + nb, 0, NRM_CEIL);
    elem_run += used;
    if (elem_run > MAX_DIM) begin
      overlong_run = 1'b1;
      elem_run     = MAX_DIM;
    end
    if (last) begin
      res.sq       = SQ_W'(sq_run);
      res.dot      = DOT_W'(dot_run);
      res.na       = NRM_W'(na_run);
      res.nb       = NRM_W'(nb_run);
      res.too_long = overlong_run;
      if (overlong_run) overlong_o++;
      if (sq_run == SQ_CEIL || dot_run == DOT_CEIL || dot_run == DOT_FLOOR ||
          na_run == NRM_CEIL || nb_run == NRM_CEIL) bounded_o++;
      expected_sums_q.push_back(res);
      clear_sums();
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_sums();
      expected_sums_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      results_o    = 0;
      overlong_o   = 0;
      bounded_o    = 0;
    end else begin
      // Compare first: a result never belongs to a request taken at the same edge
      if (out_valid_i && out_ready_i) begin
        results_o++;
        if (expected_sums_q.size() == 0) begin
          $error("result with no vector pair outstanding");
          fail_count_o++;
        end else begin
          head = expected_sums_q.pop_front();
          check_field("sum_sq_diff", 64'(head.sq), 64'(sum_sq_diff_i));
          check_field("dot_sum", 64'(head.dot), 64'(dot_sum_i));
          check_field("norm_a_sq", 64'(head.na), 64'(norm_a_sq_i));
          check_field("norm_b_sq", 64'(head.nb), 64'(norm_b_sq_i));
          check_field("too_long", 64'(head.too_long), 64'(too_long_i));
        end
      end
      if (in_valid_i && in_ready_i)
        accumulate_distance_sums(a_lanes_i, b_lanes_i, valid_count_i, last_item_i);
      pending_o = expected_sums_q.size();
    end
  end

endmodule

// ===== test/int8_vector_distance_sums_test.sv =====
// Testbench top: clock, reset, request stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps

module int8_vector_distance_sums_test;
  import ivds_pkg::*;

  typedef logic [LANES-1:0][7:0] lane_vec_t;

  // Random short vectors per idling phase, on top of the long vector pair
  localparam int SHORT_ITEMS_PER_PHASE = 230;
  // Generous bound, well above what the slowest legal run needs
  localparam int CYCLE_LIMIT  = 400_000;
  // Extra drain time after the last predicted result, to catch any stray result
  localparam int DRAIN_CYCLES = 10;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic signed [7:0]       a_lane0_i;
  logic signed [7:0]       a_lane1_i;
  logic signed [7:0]       a_lane2_i;
  logic signed [7:0]       a_lane3_i;
  logic signed [7:0]       b_lane0_i;
  logic signed [7:0]       b_lane1_i;
  logic signed [7:0]       b_lane2_i;
  logic signed [7:0]       b_lane3_i;
  logic [2:0]              valid_count_i;
  logic                    last_item_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [SQ_W-1:0]         sum_sq_diff_o;
  logic signed [DOT_W-1:0] dot_sum_o;
  logic [NRM_W-1:0]        norm_a_sq_o;
  logic [NRM_W-1:0]        norm_b_sq_o;
  logic                    too_long_o;

  int fail_count;
  int pending_pairs;
  int results_seen;
  int overlong_pairs;
  int bounded_pairs;
  int requests_sent;
  int watchdog_cycles;
  int send_idle_pct;
  int recv_idle_pct;

  // Idling per phase: receiver-heavy stalls, then sender-heavy gaps, then none
  int send_idle_tab [3] = '{35, 71, 0};
  int recv_idle_tab [3] = '{71, 35, 0};

  int8_vector_distance_sums u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .a_lane0_i     (a_lane0_i),
    .a_lane1_i     (a_lane1_i),
    .a_lane2_i     (a_lane2_i),
    .a_lane3_i     (a_lane3_i),
    .b_lane0_i     (b_lane0_i),
    .b_lane1_i     (b_lane1_i),
    .b_lane2_i     (b_lane2_i),
    .b_lane3_i     (b_lane3_i),
    .valid_count_i (valid_count_i),
    .last_item_i   (last_item_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sum_sq_diff_o (sum_sq_diff_o),
    .dot_sum_o     (dot_sum_o),
    .norm_a_sq_o   (norm_a_sq_o),
    .norm_b_sq_o   (norm_b_sq_o),
    .too_long_o    (too_long_o)
  );

  ivds_distance_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .a_lanes_i     ({a_lane3_i, a_lane2_i, a_lane1_i, a_lane0_i}),
    .b_lanes_i     ({b_lane3_i, b_lane2_i, b_lane1_i, b_lane0_i}),
    .valid_count_i (valid_count_i),
    .last_item_i   (last_item_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sum_sq_diff_i (sum_sq_diff_o),
    .dot_sum_i     (dot_sum_o),
    .norm_a_sq_i   (norm_a_sq_o),
    .norm_b_sq_i   (norm_b_sq_o),
    .too_long_i    (too_long_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending_pairs),
    .results_o     (results_seen),
    .overlong_o    (overlong_pairs),
    .bounded_o     (bounded_pairs)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: a hang or a result that never arrives ends the run here
  initial begin
    watchdog_cycles = 0;
    while (watchdog_cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      watchdog_cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Result side: redraw ready at every falling edge, stalling as the phase asks
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one request and hold it until taken. Called and left at a falling
  // edge. Valid stays high between back-to-back requests; it is dropped only
  // for an idle gap, so it never falls and rises in the same step.
  task automatic send_request(input lane_vec_t a, input lane_vec_t b,
                              input logic [2:0] cnt, input logic last);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i    <= 1'b1;
    a_lane0_i     <= a[0];
    a_lane1_i     <= a[1];
    a_lane2_i     <= a[2];
    a_lane3_i     <= a[3];
    b_lane0_i     <= b[0];
    b_lane1_i     <= b[1];
    b_lane2_i     <= b[2];
    b_lane3_i     <= b[3];
    valid_count_i <= cnt;
    last_item_i   <= last;
    do @(posedge clk_i); while (!in_ready_o);
    requests_sent++;
    @(negedge clk_i);
  endtask

  // Element values lean towards the corners of the int8 range
  function automatic lane_vec_t random_lanes();
    lane_vec_t v;
    for (int i = 0; i < LANES; i++) begin
      case ($urandom_range(7))
        0:       v[i] = 8'h80;
        1:       v[i] = 8'h7F;
        2:       v[i] = 8'h00;
        3:       v[i] = 8'hFF;
        default: v[i] = 8'($urandom);
      endcase
    end
    return v;
  endfunction

  // Mostly full requests; zero lanes and out-of-range counts now and then
  function automatic logic [2:0] random_count();
    int roll;
    roll = $urandom_range(99);
    if (roll < 50) return 3'd4;
    if (roll < 80) return 3'($urandom_range(1, 3));
    if (roll < 90) return 3'd0;
    return 3'($urandom_range(5, 7));
  endfunction

  // A vector pair of a few requests, now and then a few dozen
  task automatic send_short_pair();
    int len;
    len = ($urandom_range(99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 40);
    for (int i = 1; i <= len; i++)
      send_request(random_lanes(), random_lanes(), random_count(), i == len);
  endtask

  // Fill exactly MAX_DIM elements of -128 against 127: the squared distance,
  // the dot product floor and the first norm all land on their bounds. Then
  // either close there without the overflow flag, or run past MAX_DIM, clamp,
  // and pull the dot product back off the floor with a few same-sign requests
  // to show that the clamp acts after every request and not once at the end.
  task automatic send_long_pair();
    lane_vec_t a;
    for (int n = 0; n < MAX_DIM / LANES; n++)
      send_request({LANES{8'h80}}, {LANES{8'h7F}}, 3'd4, 1'b0);
    if ($urandom_range(1)) begin
      send_request(random_lanes(), random_lanes(), 3'd0, 1'b1);
    end else begin
      for (int n = 0; n < 6; n++)
        send_request({LANES{8'h80}}, {LANES{8'h7F}}, 3'($urandom_range(4, 7)), 1'b0);
      for (int n = 0; n < 5; n++) begin
        a = $urandom_range(1) ? {LANES{8'h7F}} : {LANES{8'h80}};
        send_request(a, a, 3'd4, 1'b0);
      end
      send_request(random_lanes(), random_lanes(), random_count(), 1'b1);
    end
  endtask

  initial begin
    int phase_start;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    a_lane0_i     = '0;
    a_lane1_i     = '0;
    a_lane2_i     = '0;
    a_lane3_i     = '0;
    b_lane0_i     = '0;
    b_lane1_i     = '0;
    b_lane2_i     = '0;
    b_lane3_i     = '0;
    valid_count_i = '0;
    last_item_i   = 1'b0;
    requests_sent = 0;
    send_idle_pct = send_idle_tab[0];
    recv_idle_pct = recv_idle_tab[0];
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: an empty pair straight after reset must read all zeros
    send_request({8'h5A, 8'hA5, 8'h3C, 8'hC3}, {8'h7F, 8'h80, 8'h01, 8'hFF}, 3'd0, 1'b1);
    // Corners of the element range
    send_request({LANES{8'h80}}, {LANES{8'h80}}, 3'd4, 1'b0);
    send_request({LANES{8'h7F}}, {LANES{8'h80}}, 3'd4, 1'b1);
    send_request({LANES{8'h80}}, {LANES{8'h7F}}, 3'd4, 1'b0);
    send_request({LANES{8'h7F}}, {LANES{8'h7F}}, 3'd4, 1'b0);
    send_request({LANES{8'h00}}, {LANES{8'hFF}}, 3'd4, 1'b1);
    // Zero lanes add nothing; a zero-lane last request still closes the pair
    send_request({LANES{8'h7F}}, {LANES{8'h80}}, 3'd0, 1'b0);
    send_request({8'h7F, 8'h80, 8'h80, 8'h7F}, {8'h80, 8'h7F, 8'h80, 8'hFF}, 3'd2, 1'b0);
    send_request({LANES{8'h80}}, {LANES{8'h7F}}, 3'd0, 1'b1);
    // Counts above the lane count act as all lanes
    send_request({8'h01, 8'h80, 8'h7F, 8'hC0}, {8'h40, 8'h7F, 8'h80, 8'hFE}, 3'd5, 1'b0);
    send_request({8'hAA, 8'h55, 8'hAA, 8'h55}, {8'h55, 8'hAA, 8'h55, 8'hAA}, 3'd6, 1'b0);
    send_request({8'h80, 8'h7F, 8'h80, 8'h7F}, {8'h7F, 8'h80, 8'h80, 8'h7F}, 3'd7, 1'b1);
    // Lanes at or above the count are ignored whatever they carry
    send_request({8'h7F, 8'h7F, 8'h80, 8'h80}, {8'h80, 8'h80, 8'h7F, 8'h7F}, 3'd1, 1'b1);
    send_request({8'h7F, 8'h33, 8'h80, 8'hF0}, {8'h80, 8'hCD, 8'h0F, 8'h10}, 3'd3, 1'b1);
    send_request({8'h00, 8'h00, 8'h00, 8'h00}, {8'h00, 8'h00, 8'h00, 8'h00}, 3'd1, 1'b1);

    // Random part: one long vector pair in the first phase, then short pairs
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = send_idle_tab[phase];
      recv_idle_pct = recv_idle_tab[phase];
      if (phase == 0) send_long_pair();
      phase_start = requests_sent;
      while (requests_sent - phase_start < SHORT_ITEMS_PER_PHASE)
        send_short_pair();
    end
    in_valid_i <= 1'b0;

    // Drain: every predicted result must come back, then allow for strays
    while (pending_pairs != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests; checked %0d vector pair results.",
             requests_sent, results_seen);
    $display("Pairs past MAX_DIM: %0d; pairs with a sum on a saturation bound: %0d.",
             overlong_pairs, bounded_pairs);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== int8_vector_distance_sums.f =====
sv/ivds_pkg.sv
sv/ivds_lane.sv
sv/ivds_merge.sv
sv/ivds_accum.sv
sv/int8_vector_distance_sums.sv
test/ivds_distance_checker.sv
test/int8_vector_distance_sums_test.sv
